// ===== src/sce_pkg.sv =====
// shared widths and defaults of the sensor change event serializer
package sce_pkg;

  localparam int unsigned MODULE_W     = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SENSOR_W     = 5;
  localparam int unsigned MOD_EXT_W    = 5;
  localparam int unsigned NUM_MODULES  = 5;

endpackage

// ===== src/sce_if.sv =====
// valid/ready channels for readings and change events
interface sce_in_if;
  logic                           valid;
  logic                           ready;
  logic [sce_pkg::MODULE_W-1:0]   module_index;
  logic [sce_pkg::BYTE_W-1:0]     contacts_a;
  logic [sce_pkg::BYTE_W-1:0]     contacts_b;

  modport source (output valid, module_index, contacts_a, contacts_b, input ready);
  modport sink   (input valid, module_index, contacts_a, contacts_b, output ready);
endinterface

interface sce_out_if;
  logic                           valid;
  logic                           ready;
  logic [sce_pkg::MODULE_W-1:0]   event_module;
  logic [sce_pkg::SENSOR_W-1:0]   sensor_number;
  logic                           released;
  logic                           last_event;

  modport source (output valid, event_module, sensor_number, released, last_event,
                  input ready);
  modport sink   (input valid, event_module, sensor_number, released, last_event,
                  output ready);
endinterface

// ===== src/sensor_change_event_serializer.sv =====
// top level: per-module change detection and serialized event output
// a reading's first event passes the memory read and compare states, then the emit register
// a new reading is taken only in idle, after all N events of the last one, N = number of
//   changed contacts (0..16); set by the single-port read/compare/write of the previous-reading
//   memory followed by the priority encoder, one event per cycle while the output is not stalled
// reset: synchronous; per-entry valid flops clear at once, so every stored
//   reading reads as zero after reset, no clearing pass is needed
module sensor_change_event_serializer #(
  parameter int unsigned NUM_MODULES = sce_pkg::NUM_MODULES
) (
  input  logic          clk,
  input  logic          rst,
  sce_in_if.sink        reading,
  sce_out_if.source     events
);

  localparam int unsigned AW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int unsigned RW = 2 * sce_pkg::BYTE_W;
  localparam int unsigned PW = 4 * sce_pkg::BYTE_W;
  localparam int unsigned PIW = $clog2(PW);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // previous reading per module: byte b high, byte a low
  logic [RW-1:0]           mem [NUM_MODULES];
  logic [RW-1:0]           mem_rdata;
  logic [NUM_MODULES-1:0]  entry_valid;

  // captured reading
  logic [AW-1:0]                    addr;
  logic [sce_pkg::MODULE_W-1:0]     cur_module;
  logic [sce_pkg::BYTE_W-1:0]       cur_a;
  logic [sce_pkg::BYTE_W-1:0]       cur_b;

  // pending change bits: rise a, rise b, fall a, fall b from lsb up
  logic [PW-1:0]  pending;

  // output register
  logic                           out_valid;
  logic [sce_pkg::MODULE_W-1:0]   out_module;
  logic [sce_pkg::SENSOR_W-1:0]   out_sensor;
  logic                           out_released;
  logic                           out_last;

  logic [sce_pkg::MOD_EXT_W-1:0]  in_idx_ext;
  logic                           in_range;
  logic                           in_xfer;
  logic [AW-1:0]                  in_addr;

  logic [RW-1:0]   prev;
  logic [PW-1:0]   change_mask;
  logic [PIW-1:0]  first_idx;
  logic [PW-1:0]   pending_clr;
  logic            out_load;
  logic [2:0]      bit_pos;

  assign in_idx_ext = {{(sce_pkg::MOD_EXT_W - sce_pkg::MODULE_W){1'b0}}, reading.module_index};
  assign in_range   = in_idx_ext < sce_pkg::MOD_EXT_W'(NUM_MODULES);
  assign in_addr    = in_idx_ext[AW-1:0];

  assign reading.ready = (state == S_IDLE);
  assign in_xfer       = reading.valid && reading.ready;

  // entries never written since reset read as zero
  assign prev = entry_valid[addr] ? mem_rdata : '0;

  assign change_mask = { prev[RW-1:sce_pkg::BYTE_W] & ~cur_b,
                         prev[sce_pkg::BYTE_W-1:0]  & ~cur_a,
                         cur_b & ~prev[RW-1:sce_pkg::BYTE_W],
                         cur_a & ~prev[sce_pkg::BYTE_W-1:0] };

  // lowest pending bit
  always_comb begin
    first_idx = '0;
    for (int i = PW - 1; i >= 0; i--) begin
      if (pending[i]) begin
        first_idx = PIW'(i);
      end
    end
  end

  always_comb begin
    pending_clr = pending;
    pending_clr[first_idx] = 1'b0;
  end

  assign bit_pos  = first_idx[2:0];
  assign out_load = (state == S_EMIT) && (!out_valid || events.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && in_range) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = (change_mask == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_load && (pending_clr == '0)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory: registered read at transfer, write back after compare
  always_ff @(posedge clk) begin
    mem_rdata <= mem[in_addr];
    if (state == S_READ) begin
      mem[addr] <= {cur_b, cur_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (state == S_READ) begin
      entry_valid[addr] <= 1'b1;
    end
  end

  // capture of the reading
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr       <= in_addr;
      cur_module <= reading.module_index;
      cur_a      <= reading.contacts_a;
      cur_b      <= reading.contacts_b;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      pending <= change_mask;
    end else if (out_load) begin
      pending <= pending_clr;
    end
  end

  // event output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_module   <= cur_module;
      // sensor 8 - bit position, plus 8 for byte b
      out_sensor   <= sce_pkg::SENSOR_W'(5'd8 - {2'b00, bit_pos})
                      + (first_idx[3] ? 5'd8 : 5'd0);
      out_released <= first_idx[4];
      out_last     <= (pending_clr == '0);
    end
  end

  assign events.valid         = out_valid;
  assign events.event_module  = out_module;
  assign events.sensor_number = out_sensor;
  assign events.released      = out_released;
  assign events.last_event    = out_last;

endmodule
